/* rtl/bimd_pkg.sv */
// ----------------------------------------------------------------------------
// bimd_pkg
// types and constants shared by the banked interrupt mask dispatcher
// ----------------------------------------------------------------------------
`default_nettype none

package bimd_pkg;

   localparam int unsigned SMALL_WIDTH = 8;
   localparam int unsigned BANK_WIDTH  = 32;

   // transaction kinds (carried in req_tuser)
   localparam logic [1:0] KIND_READ   = 2'd0;
   localparam logic [1:0] KIND_WRITE  = 2'd1;
   localparam logic [1:0] KIND_LEVELS = 2'd2;

   // source banks of a level update
   localparam logic [1:0] BANK_0     = 2'd0;
   localparam logic [1:0] BANK_1     = 2'd1;
   localparam logic [1:0] BANK_SMALL = 2'd2;

   // register word offsets
   localparam logic [3:0] REG_PEND_SMALL = 4'd0;
   localparam logic [3:0] REG_PEND_0     = 4'd1;
   localparam logic [3:0] REG_PEND_1     = 4'd2;
   localparam logic [3:0] REG_FAST_ROUTE = 4'd3;
   localparam logic [3:0] REG_EN_0       = 4'd4;
   localparam logic [3:0] REG_EN_1       = 4'd5;
   localparam logic [3:0] REG_EN_SMALL   = 4'd6;
   localparam logic [3:0] REG_DIS_0      = 4'd7;
   localparam logic [3:0] REG_DIS_1      = 4'd8;
   localparam logic [3:0] REG_DIS_SMALL  = 4'd9;

   // upper bits of the dispatch number of each bank
   localparam logic [1:0] NUM_BANK_0     = 2'd0;
   localparam logic [1:0] NUM_BANK_1     = 2'd1;
   localparam logic [1:0] NUM_BANK_SMALL = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  reg_index;
      logic [31:0] write_data;
      logic [1:0]  source_bank;
      logic [31:0] source_levels;
   } item_type;

   // enabled pending sources after the transaction has taken effect
   typedef struct packed {
      logic [SMALL_WIDTH-1:0] bank_small;
      logic [BANK_WIDTH-1:0]  bank0;
      logic [BANK_WIDTH-1:0]  bank1;
   } pend_type;

   typedef struct packed {
      logic       irq_out;
      logic [6:0] next_irq;
      logic       next_valid;
   } dispatch_type;

endpackage

`default_nettype wire

/* rtl/bimd_regs.sv */
// ----------------------------------------------------------------------------
// bimd_regs
// source levels, enable masks, fast route register and read-back mux
// ----------------------------------------------------------------------------
`default_nettype none

module bimd_regs (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire bimd_pkg::item_type item,
   output logic [31:0]             read_data,
   output bimd_pkg::pend_type      pend
);

   logic [31:0] levels0_ff, levels0_in;
   logic [31:0] levels1_ff, levels1_in;
   logic [7:0]  levels_small_ff, levels_small_in;
   logic [31:0] enable0_ff, enable0_in;
   logic [31:0] enable1_ff, enable1_in;
   logic [7:0]  enable_small_ff, enable_small_in;
   logic [7:0]  fast_route_ff, fast_route_in;
   logic [31:0] small_word;

   always_comb begin
      levels0_in      = levels0_ff;
      levels1_in      = levels1_ff;
      levels_small_in = levels_small_ff;
      enable0_in      = enable0_ff;
      enable1_in      = enable1_ff;
      enable_small_in = enable_small_ff;
      fast_route_in   = fast_route_ff;
      if (accept && item.kind == bimd_pkg::KIND_WRITE) begin
         case (item.reg_index)
            bimd_pkg::REG_FAST_ROUTE: fast_route_in   = item.write_data[7:0];
            bimd_pkg::REG_EN_0:       enable0_in      = enable0_ff | item.write_data;
            bimd_pkg::REG_EN_1:       enable1_in      = enable1_ff | item.write_data;
            bimd_pkg::REG_EN_SMALL:   enable_small_in = enable_small_ff | item.write_data[7:0];
            bimd_pkg::REG_DIS_0:      enable0_in      = enable0_ff & ~item.write_data;
            bimd_pkg::REG_DIS_1:      enable1_in      = enable1_ff & ~item.write_data;
            bimd_pkg::REG_DIS_SMALL:  enable_small_in = enable_small_ff & ~item.write_data[7:0];
            default: begin
            end
         endcase
      end else if (accept && item.kind == bimd_pkg::KIND_LEVELS) begin
         case (item.source_bank)
            bimd_pkg::BANK_0:     levels0_in      = item.source_levels;
            bimd_pkg::BANK_1:     levels1_in      = item.source_levels;
            bimd_pkg::BANK_SMALL: levels_small_in = item.source_levels[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         levels0_ff      <= '0;
         levels1_ff      <= '0;
         levels_small_ff <= '0;
         enable0_ff      <= '0;
         enable1_ff      <= '0;
         enable_small_ff <= '0;
         fast_route_ff   <= '0;
      end else begin
         levels0_ff      <= levels0_in;
         levels1_ff      <= levels1_in;
         levels_small_ff <= levels_small_in;
         enable0_ff      <= enable0_in;
         enable1_ff      <= enable1_in;
         enable_small_ff <= enable_small_in;
         fast_route_ff   <= fast_route_in;
      end
   end

   // small pending word: raw small levels, bank summaries, mirrored sources
   assign small_word = {11'd0,
                        levels1_ff[30], levels1_ff[25], levels1_ff[24], levels1_ff[23],
                        levels1_ff[22], levels1_ff[21],
                        levels0_ff[19], levels0_ff[18], levels0_ff[10], levels0_ff[9],
                        levels0_ff[7],
                        |levels1_ff, |levels0_ff,
                        levels_small_ff};

   // a read changes no state, so the current registers are what it sees
   always_comb begin
      case (item.reg_index) inside
         bimd_pkg::REG_PEND_SMALL:                   read_data = small_word;
         bimd_pkg::REG_PEND_0:                       read_data = levels0_ff;
         bimd_pkg::REG_PEND_1:                       read_data = levels1_ff;
         bimd_pkg::REG_FAST_ROUTE:                   read_data = {24'd0, fast_route_ff};
         bimd_pkg::REG_EN_0, bimd_pkg::REG_DIS_0:    read_data = enable0_ff;
         bimd_pkg::REG_EN_1, bimd_pkg::REG_DIS_1:    read_data = enable1_ff;
         bimd_pkg::REG_EN_SMALL, bimd_pkg::REG_DIS_SMALL:
            read_data = {24'd0, enable_small_ff};
         default:                                    read_data = '0;
      endcase
   end

   assign pend.bank_small = levels_small_in & enable_small_in;
   assign pend.bank0      = levels0_in & enable0_in;
   assign pend.bank1      = levels1_in & enable1_in;

endmodule

`default_nettype wire

/* rtl/bimd_prio.sv */
// ----------------------------------------------------------------------------
// bimd_prio
// fixed-order priority pick over the enabled pending sources
// ----------------------------------------------------------------------------
`default_nettype none

module bimd_prio #(
   parameter int unsigned SMALL_SOURCES = 8
) (
   input  wire bimd_pkg::pend_type pend,
   output bimd_pkg::dispatch_type  dispatch
);

   localparam logic [bimd_pkg::SMALL_WIDTH-1:0] SMALL_MASK =
      bimd_pkg::SMALL_WIDTH'((1 << SMALL_SOURCES) - 1);

   // isolate lowest set bit, then encode it with independent or terms
   function automatic logic [4:0] lowest_index(input logic [31:0] v);
      logic [31:0] one;
      logic [4:0]  idx;
      one = v & (~v + 32'd1);
      idx = '0;
      for (int i = 0; i < 32; i++) begin
         if (one[i]) idx = idx | 5'(i);
      end
      return idx;
   endfunction

   logic [bimd_pkg::SMALL_WIDTH-1:0] ps;

   assign ps = pend.bank_small & SMALL_MASK;

   always_comb begin
      dispatch.next_irq   = '0;
      dispatch.next_valid = 1'b0;
      if (ps != '0) begin
         dispatch.next_irq   = {bimd_pkg::NUM_BANK_SMALL, lowest_index({24'd0, ps})};
         dispatch.next_valid = 1'b1;
      end else if (pend.bank0 != '0) begin
         dispatch.next_irq   = {bimd_pkg::NUM_BANK_0, lowest_index(pend.bank0)};
         dispatch.next_valid = 1'b1;
      end else if (pend.bank1 != '0) begin
         dispatch.next_irq   = {bimd_pkg::NUM_BANK_1, lowest_index(pend.bank1)};
         dispatch.next_valid = 1'b1;
      end
      dispatch.irq_out = dispatch.next_valid;
   end

endmodule

`default_nettype wire

/* rtl/banked_interrupt_mask_dispatcher.sv */
// ----------------------------------------------------------------------------
// banked_interrupt_mask_dispatcher
// banked interrupt controller with set/clear enable registers
// ----------------------------------------------------------------------------
// Every transaction on the req stream is a register read, a register write or
// a raw level update of one source bank, and produces exactly one rsp
// transaction in the cycle after it is accepted: the read data (zero for
// anything but a read) and the dispatch view of the state after the
// transaction took effect - irq_out, and next_irq/next_valid naming the first
// enabled pending source, small bank first (64 + bit), then bank 0 (bit),
// then bank 1 (32 + bit). A new transaction is taken every cycle; req_tready
// only drops while a result sits in the output register and rsp_tready is low.
// Throughput is one transaction per cycle; the single output register behind
// the register file and priority encoder holds each result.
// ----------------------------------------------------------------------------
`default_nettype none

module banked_interrupt_mask_dispatcher #(
   parameter int unsigned SMALL_SOURCES = 8   // small bank sources that may be dispatched, 1..8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // reg_index [3:0], write_data [35:4], source_bank [37:36],
   // source_levels [69:38], zero fill [71:70]
   input  wire logic [71:0] req_tdata,
   // kind [1:0]
   input  wire logic [1:0]  req_tuser,
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // read_data [31:0], irq_out [32], next_irq [39:33], next_valid [40],
   // zero fill [47:41]
   output logic [47:0]      rsp_tdata
);

   bimd_pkg::item_type     item;
   bimd_pkg::pend_type     pend;
   bimd_pkg::dispatch_type dispatch;
   logic [31:0]            read_data;
   logic                   accept;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [40:0] rsp_data_ff, rsp_data_in;

   // unpack the request transaction
   assign item.kind          = req_tuser;
   assign item.reg_index     = req_tdata[3:0];
   assign item.write_data    = req_tdata[35:4];
   assign item.source_bank   = req_tdata[37:36];
   assign item.source_levels = req_tdata[69:38];

   // output register frees up when empty or being drained this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // register file updates on accept; pend reflects the updated state
   bimd_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .item      (item),
      .read_data (read_data),
      .pend      (pend)
   );

   bimd_prio #(
      .SMALL_SOURCES (SMALL_SOURCES)
   ) u_prio (
      .pend     (pend),
      .dispatch (dispatch)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {dispatch.next_valid, dispatch.next_irq, dispatch.irq_out,
                         (item.kind == bimd_pkg::KIND_READ) ? read_data : 32'd0};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload holds no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};

endmodule

`default_nettype wire

/* rtl/bimd_checker.sv */
// ----------------------------------------------------------------------------
// bimd_checker
// port-level checks for the banked interrupt mask dispatcher
// ----------------------------------------------------------------------------
`default_nettype none

module bimd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata
);

   // no result straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // an empty output register never stalls the request side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output");

   // a stalled response holds its transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // irq_out and next_valid agree, and no number without a source
   a_valid_agree: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[32] == rsp_tdata[40]) &&
                     (rsp_tdata[40] || rsp_tdata[39:33] == 7'd0))
      else $error("dispatch flags inconsistent");

   // small bank numbers stay within 64..71
   a_small_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[39] |-> rsp_tdata[38:36] == 3'd0)
      else $error("source number out of range");

endmodule

bind banked_interrupt_mask_dispatcher bimd_checker u_bimd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

/* tb/sv/bimd_tb_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bimd_tb_pkg
// scoreboard of the banked interrupt mask dispatcher: keeps its own copy of
// the levels, masks and fast route byte and predicts every response
// ----------------------------------------------------------------------------

package bimd_tb_pkg;

   import bimd_pkg::*;

   typedef struct {
      logic [31:0]  read_data;
      dispatch_type dispatch;
   } dispatch_response_t;

   class irq_dispatch_scoreboard;

      bit [31:0]          levels0, levels1, enable0, enable1;
      bit [7:0]           levels_small, enable_small, fast_route;
      bit [7:0]           small_dispatch_mask;
      dispatch_response_t predicted_rsp_q[$];
      int unsigned        errors;

      function new(int unsigned small_sources);
         small_dispatch_mask = (small_sources >= SMALL_WIDTH) ? 8'hff
                                                              : 8'((1 << small_sources) - 1);
         errors = 0;
      endfunction

      // raw small levels, bank summaries and the mirrored sources
      function bit [31:0] small_pending_word();
         bit [31:0] w;
         w        = {24'b0, levels_small};
         w[8]     = |levels0;
         w[9]     = |levels1;
         w[10]    = levels0[7];
         w[11]    = levels0[9];
         w[12]    = levels0[10];
         w[13]    = levels0[18];
         w[14]    = levels0[19];
         // sources 53 to 57 and 62 live in bank 1
         w[19:15] = levels1[25:21];
         w[20]    = levels1[30];
         return w;
      endfunction

      function bit [31:0] register_value(logic [3:0] idx);
         case (idx)
            REG_PEND_SMALL:           return small_pending_word();
            REG_PEND_0:               return levels0;
            REG_PEND_1:               return levels1;
            REG_FAST_ROUTE:           return {24'b0, fast_route};
            REG_EN_0, REG_DIS_0:      return enable0;
            REG_EN_1, REG_DIS_1:      return enable1;
            REG_EN_SMALL, REG_DIS_SMALL: return {24'b0, enable_small};
            default:                  return '0;
         endcase
      endfunction

      function void apply_write(logic [3:0] idx, logic [31:0] data);
         case (idx)
            REG_FAST_ROUTE: fast_route   = data[7:0];
            REG_EN_0:       enable0      = enable0 | data;
            REG_EN_1:       enable1      = enable1 | data;
            REG_EN_SMALL:   enable_small = enable_small | data[7:0];
            REG_DIS_0:      enable0      = enable0 & ~data;
            REG_DIS_1:      enable1      = enable1 & ~data;
            REG_DIS_SMALL:  enable_small = enable_small & ~data[7:0];
            default: ;
         endcase
      endfunction

      function bit [4:0] lowest_set(bit [31:0] v);
         for (int b = 0; b < 32; b++)
            if (v[b])
               return 5'(b);
         return '0;
      endfunction

      function void note_request(logic [1:0] kind, logic [3:0] idx, logic [31:0] wdata,
                                 logic [1:0] bank, logic [31:0] lv);
         dispatch_response_t r;
         bit [31:0]          ps, p0, p1;
         r.read_data = '0;
         r.dispatch  = '0;
         case (kind)
            KIND_READ:  r.read_data = register_value(idx);
            KIND_WRITE: apply_write(idx, wdata);
            KIND_LEVELS: begin
               case (bank)
                  BANK_0:     levels0      = lv;
                  BANK_1:     levels1      = lv;
                  BANK_SMALL: levels_small = lv[7:0];
                  default: ;
               endcase
            end
            default: ;
         endcase
         ps = {24'b0, levels_small & enable_small & small_dispatch_mask};
         p0 = levels0 & enable0;
         p1 = levels1 & enable1;
         if (ps != 0)
            r.dispatch.next_irq = {NUM_BANK_SMALL, lowest_set(ps)};
         else if (p0 != 0)
            r.dispatch.next_irq = {NUM_BANK_0, lowest_set(p0)};
         else if (p1 != 0)
            r.dispatch.next_irq = {NUM_BANK_1, lowest_set(p1)};
         r.dispatch.next_valid = (ps != 0) || (p0 != 0) || (p1 != 0);
         r.dispatch.irq_out    = r.dispatch.next_valid;
         predicted_rsp_q.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      // rsp_tdata: read_data [31:0], irq_out [32], next_irq [39:33], next_valid [40]
      function void check_response(logic [47:0] data);
         dispatch_response_t want;
         if (predicted_rsp_q.size() == 0) begin
            $error("response transaction with nothing predicted: 0x%0h", data);
            errors++;
            return;
         end
         want = predicted_rsp_q.pop_front();
         compare_field("read_data", want.read_data, data[31:0]);
         compare_field("irq_out", 32'(want.dispatch.irq_out), 32'(data[32]));
         compare_field("next_irq", 32'(want.dispatch.next_irq), 32'(data[39:33]));
         compare_field("next_valid", 32'(want.dispatch.next_valid), 32'(data[40]));
      endfunction

      function int unsigned outstanding();
         return predicted_rsp_q.size();
      endfunction

   endclass

endpackage

/* tb/sv/tb_banked_interrupt_mask_dispatcher.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_banked_interrupt_mask_dispatcher
// self-checking bench for the banked interrupt mask dispatcher
// ----------------------------------------------------------------------------
// A directed run covers register reads of every offset but 4 and 8, set of
// every mask, clear of all but the bank 1 mask, the dispatch order across
// banks and the ignored cases; then random reads, writes and level updates
// follow in phases with varied sender idling and receiver back-pressure,
// including a long receiver hold-off that fills the block. Every response
// is checked against the scoreboard's prediction field by field.
// ----------------------------------------------------------------------------

module tb_banked_interrupt_mask_dispatcher;

   import bimd_pkg::*;
   import bimd_tb_pkg::*;

   localparam int unsigned SMALL_SRC    = 8;
   localparam int unsigned HOLD_CYCLES  = 60;
   localparam int unsigned PHASE_ITEMS  = 375;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   // reg_index [3:0], write_data [35:4], source_bank [37:36],
   // source_levels [69:38], zero fill [71:70]
   logic [71:0] req_tdata   = '0;
   // kind [1:0]
   logic [1:0]  req_tuser   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   // read_data [31:0], irq_out [32], next_irq [39:33], next_valid [40],
   // zero fill [47:41]
   logic [47:0] rsp_tdata;

   // idle percentages of the current phase, read by the driving processes
   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   // set by the stimulus, picked up and counted down by the receiver
   bit          hold_request = 1'b0;
   int unsigned hold_left    = 0;

   irq_dispatch_scoreboard sb;

   banked_interrupt_mask_dispatcher #(
      .SMALL_SOURCES (SMALL_SRC)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // response side: random stalls, or a long hold-off when asked for
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // transaction monitor: signals are sampled before this edge's updates land
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata[3:0], req_tdata[35:4],
                            req_tdata[37:36], req_tdata[69:38]);
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata);
      end
   end

   // offer one transaction, after random idling
   task automatic send_item(input logic [1:0] kind, input logic [3:0] idx,
                            input logic [31:0] wdata, input logic [1:0] bank,
                            input logic [31:0] lv);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, lv, bank, wdata, idx};
      do
         @(posedge clock);
      while (!req_tready);
   endtask

   // stop offering and wait until every predicted response has arrived
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0)
         @(posedge clock);
   endtask

   // mostly sparse or extreme words so that masks and levels overlap often
   function automatic logic [31:0] random_word();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2, 3:    return 32'h1 << $urandom_range(31);
         4:       return $urandom & $urandom & $urandom;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random_item();
      int unsigned sel;
      logic [1:0]  kind;
      logic [3:0]  idx;
      logic [1:0]  bank;
      sel  = $urandom_range(99);
      kind = (sel < 30) ? KIND_READ : (sel < 65) ? KIND_WRITE
           : (sel < 95) ? KIND_LEVELS : 2'd3;
      // unused offsets now and then
      idx  = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
      bank = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
      send_item(kind, idx, random_word(), bank, random_word());
   endtask

   task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                            input bit with_hold);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         // long receiver hold-off half way through, sender keeps offering
         if (with_hold && n == PHASE_ITEMS / 2)
            hold_request = 1'b1;
         send_random_item();
      end
      wait_drained();
   endtask

   task automatic directed_items();
      // everything pending, nothing enabled
      send_item(KIND_LEVELS, REG_PEND_SMALL, '0, BANK_0, 32'hffff_ffff);
      send_item(KIND_LEVELS, REG_PEND_SMALL, '0, BANK_1, 32'hffff_ffff);
      // small bank keeps only the low byte
      send_item(KIND_LEVELS, REG_PEND_SMALL, '0, BANK_SMALL, 32'hffff_ffff);
      send_item(KIND_READ, REG_PEND_SMALL, '0, BANK_0, '0);
      // bank 0 enables, then bank 1 top bit, then small bank wins
      send_item(KIND_WRITE, REG_EN_0, 32'hffff_ffff, BANK_0, '0);
      send_item(KIND_WRITE, REG_EN_1, 32'h8000_0000, BANK_0, '0);
      send_item(KIND_WRITE, REG_EN_SMALL, 32'h0000_0080, BANK_0, '0);
      send_item(KIND_READ, REG_EN_SMALL, '0, BANK_0, '0);
      send_item(KIND_READ, REG_DIS_SMALL, '0, BANK_0, '0);
      send_item(KIND_WRITE, REG_DIS_SMALL, 32'hffff_ffff, BANK_0, '0);
      // clear down to bank 0 top bit, then fall through to bank 1
      send_item(KIND_WRITE, REG_DIS_0, 32'h7fff_ffff, BANK_0, '0);
      send_item(KIND_WRITE, REG_DIS_0, 32'hffff_ffff, BANK_0, '0);
      send_item(KIND_WRITE, REG_FAST_ROUTE, 32'hffff_ffff, BANK_0, '0);
      send_item(KIND_READ, REG_FAST_ROUTE, '0, BANK_0, '0);
      // pending registers are read only, unused offsets read zero
      send_item(KIND_WRITE, REG_PEND_0, 32'h0000_0000, BANK_0, '0);
      send_item(KIND_WRITE, 4'hf, 32'hffff_ffff, BANK_0, '0);
      send_item(KIND_READ, 4'hf, '0, BANK_0, '0);
      send_item(KIND_READ, 4'ha, '0, BANK_0, '0);
      // unused kind and unused bank change nothing
      send_item(2'd3, REG_EN_0, 32'hffff_ffff, BANK_0, 32'h0);
      send_item(KIND_LEVELS, REG_PEND_SMALL, '0, 2'd3, 32'h0);
      send_item(KIND_LEVELS, REG_PEND_SMALL, '0, BANK_0, 32'h0);
      send_item(KIND_READ, REG_PEND_0, '0, BANK_0, '0);
      send_item(KIND_READ, REG_PEND_1, '0, BANK_0, '0);
      send_item(KIND_READ, REG_DIS_0, '0, BANK_0, '0);
      send_item(KIND_READ, REG_EN_1, '0, BANK_0, '0);
   endtask

   initial begin
      sb = new(SMALL_SRC);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_items();
      wait_drained();

      run_phase(0, 0, 1'b1);
      run_phase(67, 0, 1'b0);
      run_phase(0, 67, 1'b1);
      run_phase(19, 19, 1'b0);

      repeat (4) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
